### rtl/dcd_pkg.sv
package dcd_pkg;

  // Fixed internal widths of the normalized datapath.
  localparam int N_W      = 31;  // normalized magnitude, top bit at 2^30
  localparam int SQ_W     = 64;  // sum of three squared magnitudes
  localparam int ROOT_W   = 32;  // integer square root of the sum
  localparam int SQ_REM_W = 34;  // square root partial remainder
  localparam int DIR_W    = 32;  // direction component, Q2.30
  localparam int PROD_W   = 62;  // product of two direction magnitudes
  localparam int NUM_W    = 61;  // Hessian numerator magnitude, scale 2^60

  // Direction divider geometry: dividend 63 bits, divisor 2L.
  localparam int DD_DVW = 33;
  localparam int DD_QW  = 32;

  // Numerator of one, scale 2^60.
  localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1) << 60;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [1:0] CFG_OFFSET_Z = 2'd2;

endpackage

### rtl/dcd_sqrt_cell.sv
module dcd_sqrt_cell #(
  parameter int PW = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_v,
  input  logic [dcd_pkg::SQ_REM_W-1:0]    in_rem,
  input  logic [dcd_pkg::ROOT_W-1:0]      in_root,
  input  logic [dcd_pkg::SQ_W-1:0]        in_rad,
  input  logic [PW-1:0]                   in_pay,
  output logic                            out_v,
  output logic [dcd_pkg::SQ_REM_W-1:0]    out_rem,
  output logic [dcd_pkg::ROOT_W-1:0]      out_root,
  output logic [dcd_pkg::SQ_W-1:0]        out_rad,
  output logic [PW-1:0]                   out_pay
);

  localparam int TW = dcd_pkg::SQ_REM_W + 2;

  logic [TW-1:0] t;
  logic [TW-1:0] trial;
  logic          ge;

  // One root bit: bring down two radicand bits and try (root << 2) | 1.
  assign t     = {in_rem, in_rad[dcd_pkg::SQ_W-1 -: 2]};
  assign trial = TW'({in_root, 2'b01});
  assign ge    = t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? dcd_pkg::SQ_REM_W'(t - trial) : dcd_pkg::SQ_REM_W'(t);
      out_root <= {in_root[dcd_pkg::ROOT_W-2:0], ge};
      out_rad  <= in_rad << 2;
      out_pay  <= in_pay;
    end
  end

endmodule

### rtl/dcd_div_cell.sv
module dcd_div_cell #(
  parameter int LANES = 3,
  parameter int DVW   = 33,
  parameter int LW    = 32,
  parameter int QW    = 32,
  parameter int PW    = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [DVW-1:0]              in_div,
  input  logic [LANES-1:0][DVW-1:0]   in_rem,
  input  logic [LANES-1:0][LW-1:0]    in_dvd,
  input  logic [LANES-1:0][QW-1:0]    in_quo,
  input  logic [PW-1:0]               in_pay,
  output logic                        out_v,
  output logic [DVW-1:0]              out_div,
  output logic [LANES-1:0][DVW-1:0]   out_rem,
  output logic [LANES-1:0][LW-1:0]    out_dvd,
  output logic [LANES-1:0][QW-1:0]    out_quo,
  output logic [PW-1:0]               out_pay
);

  logic [LANES-1:0][DVW:0]   t;
  logic [LANES-1:0][DVW-1:0] rem_next;
  logic [LANES-1:0]          ge;

  // One restoring step per lane: shift in a dividend bit, subtract if it fits.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign t[l]        = {in_rem[l], in_dvd[l][LW-1]};
    assign ge[l]       = t[l] >= {1'b0, in_div};
    assign rem_next[l] = ge[l] ? DVW'(t[l] - {1'b0, in_div}) : DVW'(t[l]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div <= in_div;
      out_pay <= in_pay;
      for (int l = 0; l < LANES; l++) begin
        out_rem[l] <= rem_next[l];
        out_dvd[l] <= in_dvd[l] << 1;
        out_quo[l] <= {in_quo[l][QW-2:0], ge[l]};
      end
    end
  end

endmodule

### rtl/distance_constraint_derivatives.sv
// Distance constraint derivatives. Each item carries two points in signed
// fixed point with FRAC_BITS fraction bits; the block forms a = offset +
// second - first and returns the unit direction a/l in Q2.30 and the six
// distinct Hessian entries (l^2 - a_i^2)/l^3 and -a_i*a_j/l^3, saturated to
// COORD_WIDTH bits with a flag. A zero difference vector raises zero_length
// and zeroes every other field. The block takes one item per clock while
// in_stall is low and is fully pipelined: a chain of 32 square root cells,
// a chain of 32 direction divider cells and a chain of
// 31 + max(0, 2*FRAC_BITS - 29) Hessian divider cells, one bit per cell.
// A two-entry output stage lets the pipeline keep accepting while a result
// waits; in_stall rises only when that stage is full.
module distance_constraint_derivatives #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            dir_x,
  output logic signed [31:0]            dir_y,
  output logic signed [31:0]            dir_z,
  output logic signed [COORD_WIDTH-1:0] hess_xx,
  output logic signed [COORD_WIDTH-1:0] hess_yy,
  output logic signed [COORD_WIDTH-1:0] hess_zz,
  output logic signed [COORD_WIDTH-1:0] hess_xy,
  output logic signed [COORD_WIDTH-1:0] hess_xz,
  output logic signed [COORD_WIDTH-1:0] hess_yz,
  output logic                          zero_length,
  output logic                          saturated
);

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = CW + 2;
  localparam int MW    = CW + 1;
  localparam int P_W   = $clog2(CW + 1);
  localparam int KMAX  = (2 * FRAC_BITS - 29 > 0) ? 2 * FRAC_BITS - 29 : 0;
  localparam int QB    = 31 + KMAX;
  localparam int JC    = KMAX - 2 * FRAC_BITS + 29;
  localparam int J_W   = $clog2(JC + CW + 1);
  localparam int QX    = QB + CW;
  localparam int NW    = dcd_pkg::N_W;
  localparam int DW    = dcd_pkg::DIR_W;
  localparam int SPW   = 3 + P_W + 1 + 3 * NW;
  localparam int DPW   = 3 + P_W + 1 + dcd_pkg::ROOT_W;
  localparam int HPW   = 3 * DW + 6 + P_W + 1;
  localparam int RW    = 3 * DW + 6 * CW + 2;
  localparam int SQN   = dcd_pkg::ROOT_W;
  localparam int DDN   = dcd_pkg::DD_QW;
  localparam int DDV   = dcd_pkg::DD_DVW;
  localparam int HDV   = dcd_pkg::ROOT_W;
  localparam int ROOT_W_L = dcd_pkg::ROOT_W;

  logic en;

  // Configuration registers, written at any time the port is driven.
  logic [CW-1:0] off_x, off_y, off_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dcd_pkg::CFG_OFFSET_X: off_x <= cfg_data;
        dcd_pkg::CFG_OFFSET_Y: off_y <= cfg_data;
        dcd_pkg::CFG_OFFSET_Z: off_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: difference vector.
  logic                        s1_v;
  logic [2:0][AW-1:0]          s1_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a[0] <= AW'($signed(off_x)) + AW'(second_x) - AW'(first_x);
      s1_a[1] <= AW'($signed(off_y)) + AW'(second_y) - AW'(first_y);
      s1_a[2] <= AW'($signed(off_z)) + AW'(second_z) - AW'(first_z);
    end
  end

  // Stage 2: sign and magnitude.
  logic                s2_v;
  logic [2:0]          s2_s;
  logic [2:0][MW-1:0]  s2_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_s[i] <= s1_a[i][AW-1];
        s2_m[i] <= s1_a[i][AW-1] ? MW'(-s1_a[i]) : MW'(s1_a[i]);
      end
    end
  end

  // Stage 3: position of the top set bit of the largest magnitude.
  logic [MW-1:0]  orv;
  logic [P_W-1:0] p_c;

  assign orv = s2_m[0] | s2_m[1] | s2_m[2];

  always_comb begin
    p_c = '0;
    for (int b = 0; b < MW; b++) begin
      if (orv[b]) begin
        p_c = P_W'(b);
      end
    end
  end

  logic                s3_v;
  logic [2:0]          s3_s;
  logic [2:0][MW-1:0]  s3_m;
  logic [P_W-1:0]      s3_p;
  logic                s3_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_s <= s2_s;
      s3_m <= s2_m;
      s3_p <= p_c;
      s3_z <= (orv == '0);
    end
  end

  // Stage 4: normalize so the largest magnitude sits in [2^30, 2^31).
  logic                s4_v;
  logic [2:0]          s4_s;
  logic [2:0][NW-1:0]  s4_n;
  logic [P_W-1:0]      s4_p;
  logic                s4_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_n[i] <= NW'({s3_m[i], 30'b0} >> s3_p);
      end
      s4_s <= s3_s;
      s4_p <= s3_p;
      s4_z <= s3_z;
    end
  end

  // Stage 5: squares.
  logic                                 s5_v;
  logic [2:0]                           s5_s;
  logic [2:0][NW-1:0]                   s5_n;
  logic [2:0][dcd_pkg::PROD_W-1:0]      s5_q;
  logic [P_W-1:0]                       s5_p;
  logic                                 s5_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_q[i] <= dcd_pkg::PROD_W'(s4_n[i]) * dcd_pkg::PROD_W'(s4_n[i]);
      end
      s5_n <= s4_n;
      s5_s <= s4_s;
      s5_p <= s4_p;
      s5_z <= s4_z;
    end
  end

  // Stage 6: sum of squares.
  logic                       s6_v;
  logic [dcd_pkg::SQ_W-1:0]   s6_sum;
  logic [SPW-1:0]             s6_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sum <= dcd_pkg::SQ_W'(s5_q[0]) + dcd_pkg::SQ_W'(s5_q[1])
              + dcd_pkg::SQ_W'(s5_q[2]);
      s6_pay <= {s5_s, s5_p, s5_z, s5_n[2], s5_n[1], s5_n[0]};
    end
  end

  // Square root chain, one root bit per cell.
  logic                           sq_v    [SQN+1];
  logic [dcd_pkg::SQ_REM_W-1:0]   sq_rem  [SQN+1];
  logic [dcd_pkg::ROOT_W-1:0]     sq_root [SQN+1];
  logic [dcd_pkg::SQ_W-1:0]       sq_rad  [SQN+1];
  logic [SPW-1:0]                 sq_pay  [SQN+1];

  assign sq_v[0]    = s6_v;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = s6_sum;
  assign sq_pay[0]  = s6_pay;

  for (genvar c = 0; c < SQN; c++) begin : g_sqrt
    dcd_sqrt_cell #(.PW(SPW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_v     (sq_v[c]),
      .in_rem   (sq_rem[c]),
      .in_root  (sq_root[c]),
      .in_rad   (sq_rad[c]),
      .in_pay   (sq_pay[c]),
      .out_v    (sq_v[c+1]),
      .out_rem  (sq_rem[c+1]),
      .out_root (sq_root[c+1]),
      .out_rad  (sq_rad[c+1]),
      .out_pay  (sq_pay[c+1])
    );
  end

  // Stage 7: direction dividends (n << 31) + L over divisor 2L.
  logic [2:0]              sq_s;
  logic [P_W-1:0]          sq_p;
  logic                    sq_z;
  logic [2:0][NW-1:0]      sq_n;
  logic [ROOT_W_L-1:0]     len;
  logic [2:0][62:0]        dx;

  assign {sq_s, sq_p, sq_z, sq_n[2], sq_n[1], sq_n[0]} = sq_pay[SQN];
  assign len = sq_root[SQN];

  for (genvar i = 0; i < 3; i++) begin : g_dx
    assign dx[i] = {sq_n[i], 32'b0} >> 1;
  end

  logic                       s7_v;
  logic [DDV-1:0]             s7_div;
  logic [2:0][DDV-1:0]        s7_rem;
  logic [2:0][DDN-1:0]        s7_dvd;
  logic [DPW-1:0]             s7_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= sq_v[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_rem[i] <= DDV'((dx[i] + 63'(len)) >> 32);
        s7_dvd[i] <= DDN'(dx[i] + 63'(len));
      end
      s7_div <= {len, 1'b0};
      s7_pay <= {sq_s, sq_p, sq_z, len};
    end
  end

  // Direction divider chain, one quotient bit per cell.
  logic                       dd_v   [DDN+1];
  logic [DDV-1:0]             dd_div [DDN+1];
  logic [2:0][DDV-1:0]        dd_rem [DDN+1];
  logic [2:0][DDN-1:0]        dd_dvd [DDN+1];
  logic [2:0][DDN-1:0]        dd_quo [DDN+1];
  logic [DPW-1:0]             dd_pay [DDN+1];

  assign dd_v[0]   = s7_v;
  assign dd_div[0] = s7_div;
  assign dd_rem[0] = s7_rem;
  assign dd_dvd[0] = s7_dvd;
  assign dd_quo[0] = '0;
  assign dd_pay[0] = s7_pay;

  for (genvar c = 0; c < DDN; c++) begin : g_ddiv
    dcd_div_cell #(
      .LANES (3),
      .DVW   (DDV),
      .LW    (DDN),
      .QW    (DDN),
      .PW    (DPW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_v    (dd_v[c]),
      .in_div  (dd_div[c]),
      .in_rem  (dd_rem[c]),
      .in_dvd  (dd_dvd[c]),
      .in_quo  (dd_quo[c]),
      .in_pay  (dd_pay[c]),
      .out_v   (dd_v[c+1]),
      .out_div (dd_div[c+1]),
      .out_rem (dd_rem[c+1]),
      .out_dvd (dd_dvd[c+1]),
      .out_quo (dd_quo[c+1]),
      .out_pay (dd_pay[c+1])
    );
  end

  // Stage 8: direction magnitudes, signed directions and products.
  logic [2:0]              dd_s;
  logic [P_W-1:0]          dd_p;
  logic                    dd_z;
  logic [ROOT_W_L-1:0]     dd_len;
  logic [2:0][NW-1:0]      dm;

  assign {dd_s, dd_p, dd_z, dd_len} = dd_pay[DDN];

  for (genvar i = 0; i < 3; i++) begin : g_dm
    assign dm[i] = NW'(dd_quo[DDN][i]);
  end

  logic                              s8_v;
  logic [5:0][dcd_pkg::PROD_W-1:0]   s8_prod;
  logic [2:0][DW-1:0]                s8_dir;
  logic [2:0]                        s8_s;
  logic [P_W-1:0]                    s8_p;
  logic                              s8_z;
  logic [ROOT_W_L-1:0]               s8_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= dd_v[DDN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s8_prod[i] <= dcd_pkg::PROD_W'(dm[i]) * dcd_pkg::PROD_W'(dm[i]);
        s8_dir[i]  <= dd_s[i] ? DW'(-DW'(dm[i])) : DW'(dm[i]);
      end
      s8_prod[3] <= dcd_pkg::PROD_W'(dm[0]) * dcd_pkg::PROD_W'(dm[1]);
      s8_prod[4] <= dcd_pkg::PROD_W'(dm[0]) * dcd_pkg::PROD_W'(dm[2]);
      s8_prod[5] <= dcd_pkg::PROD_W'(dm[1]) * dcd_pkg::PROD_W'(dm[2]);
      s8_s   <= dd_s;
      s8_p   <= dd_p;
      s8_z   <= dd_z;
      s8_len <= dd_len;
    end
  end

  // Stage 9: Hessian numerators and their signs.
  logic [5:0][dcd_pkg::NUM_W-1:0] num;
  logic [5:0]                     neg;

  for (genvar i = 0; i < 3; i++) begin : g_num
    assign num[i]   = dcd_pkg::NUM_ONE - dcd_pkg::NUM_W'(s8_prod[i]);
    assign num[i+3] = dcd_pkg::NUM_W'(s8_prod[i+3]);
    assign neg[i]   = 1'b0;
  end
  assign neg[3] = s8_s[0] == s8_s[1];
  assign neg[4] = s8_s[0] == s8_s[2];
  assign neg[5] = s8_s[1] == s8_s[2];

  logic                    s9_v;
  logic [HDV-1:0]          s9_div;
  logic [5:0][HDV-1:0]     s9_rem;
  logic [5:0][QB-1:0]      s9_dvd;
  logic [HPW-1:0]          s9_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        s9_rem[l] <= HDV'(num[l] >> 31);
        s9_dvd[l] <= QB'(num[l][30:0]) << KMAX;
      end
      s9_div <= s8_len;
      s9_pay <= {s8_dir[2], s8_dir[1], s8_dir[0], neg, s8_p, s8_z};
    end
  end

  // Hessian divider chain, one quotient bit per cell.
  logic                    hd_v   [QB+1];
  logic [HDV-1:0]          hd_div [QB+1];
  logic [5:0][HDV-1:0]     hd_rem [QB+1];
  logic [5:0][QB-1:0]      hd_dvd [QB+1];
  logic [5:0][QB-1:0]      hd_quo [QB+1];
  logic [HPW-1:0]          hd_pay [QB+1];

  assign hd_v[0]   = s9_v;
  assign hd_div[0] = s9_div;
  assign hd_rem[0] = s9_rem;
  assign hd_dvd[0] = s9_dvd;
  assign hd_quo[0] = '0;
  assign hd_pay[0] = s9_pay;

  for (genvar c = 0; c < QB; c++) begin : g_hdiv
    dcd_div_cell #(
      .LANES (6),
      .DVW   (HDV),
      .LW    (QB),
      .QW    (QB),
      .PW    (HPW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_v    (hd_v[c]),
      .in_div  (hd_div[c]),
      .in_rem  (hd_rem[c]),
      .in_dvd  (hd_dvd[c]),
      .in_quo  (hd_quo[c]),
      .in_pay  (hd_pay[c]),
      .out_v   (hd_v[c+1]),
      .out_div (hd_div[c+1]),
      .out_rem (hd_rem[c+1]),
      .out_dvd (hd_dvd[c+1]),
      .out_quo (hd_quo[c+1]),
      .out_pay (hd_pay[c+1])
    );
  end

  // Stage 10: scale the quotient to the output format and flag overflow.
  logic [2:0][DW-1:0]  hd_dir;
  logic [5:0]          hd_neg;
  logic [P_W-1:0]      hd_p;
  logic                hd_z;
  logic [J_W-1:0]      jsh;

  assign {hd_dir[2], hd_dir[1], hd_dir[0], hd_neg, hd_p, hd_z} = hd_pay[QB];
  assign jsh = J_W'(hd_p) + J_W'(JC);

  logic [5:0][QX-1:0]  qs;

  for (genvar l = 0; l < 6; l++) begin : g_qs
    assign qs[l] = QX'(hd_quo[QB][l]) >> jsh;
  end

  logic                s10_v;
  logic [5:0][CW-1:0]  s10_q;
  logic [5:0]          s10_over;
  logic [5:0]          s10_neg;
  logic [2:0][DW-1:0]  s10_dir;
  logic                s10_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= hd_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        s10_q[l]    <= qs[l][CW-1:0];
        s10_over[l] <= |qs[l][QX-1:CW];
      end
      s10_neg <= hd_neg;
      s10_dir <= hd_dir;
      s10_z   <= hd_z;
    end
  end

  // Stage 11: round half up, clamp to range, apply sign.
  logic [5:0][CW:0]    rnd;
  logic [5:0][CW:0]    lim;
  logic [5:0]          clip;
  logic [5:0][CW:0]    mag;
  logic [5:0][CW-1:0]  hval;

  for (genvar l = 0; l < 6; l++) begin : g_fin
    assign rnd[l]  = ({1'b0, s10_q[l]} + (CW+1)'(1)) >> 1;
    assign lim[l]  = s10_neg[l] ? ((CW+1)'(1) << (CW-1))
                                : ((CW+1)'(1) << (CW-1)) - (CW+1)'(1);
    assign clip[l] = s10_over[l] || (rnd[l] > lim[l]);
    assign mag[l]  = clip[l] ? lim[l] : rnd[l];
    assign hval[l] = s10_neg[l] ? CW'(-mag[l][CW-1:0]) : mag[l][CW-1:0];
  end

  logic [RW-1:0] res_c;

  always_comb begin
    if (s10_z) begin
      res_c = {1'b1, 1'b0, (RW-2)'(0)};
    end else begin
      res_c = {1'b0, |clip, hval[5], hval[4], hval[3], hval[2], hval[1], hval[0],
               s10_dir[2], s10_dir[1], s10_dir[0]};
    end
  end

  logic          s11_v;
  logic [RW-1:0] s11_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (en) begin
      s11_v <= s10_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_res <= res_c;
    end
  end

  // Output register with a skid entry behind it; the pipeline halts only
  // when the skid entry is occupied.
  logic          out_v;
  logic [RW-1:0] out_res;
  logic          skid_v;
  logic [RW-1:0] skid_res;
  logic          take;
  logic          push;

  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign take     = out_v && !out_stall;
  assign push     = en && s11_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!out_v || take) begin
        out_v  <= skid_v || push;
        skid_v <= 1'b0;
      end else if (push) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || take) begin
      out_res <= skid_v ? skid_res : s11_res;
    end
    if (out_v && !take && push) begin
      skid_res <= s11_res;
    end
  end

  assign out_valid = out_v;
  assign {zero_length, saturated, hess_yz, hess_xz, hess_xy, hess_zz, hess_yy,
          hess_xx, dir_z, dir_y, dir_x} = out_res;

endmodule

### tb/distance_constraint_derivatives_tb.sv
module distance_constraint_derivatives_tb;

  localparam int FRAC = 16;
  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 150;
  // Register index past the last offset register; writes to it are ignored.
  localparam logic [1:0] CFG_NONE = 2'd3;

  typedef struct {
    logic signed [31:0] dir[3];
    logic signed [31:0] hess[6];
    logic zl;
    logic sat;
  } deriv_t;

  // Golden model of the derivative pipeline plus the queue of pending results.
  class deriv_scoreboard;
    longint offset[3];
    deriv_t pending[$];
    int errors;

    function new();
      offset = '{0, 0, 0};
      errors = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Rounded num * 2^(k-1) / len, clamped to 32 bits.
    function automatic logic [31:0] scale_entry(longint num, int k, longint unsigned len,
                                                inout logic sat);
      logic neg;
      longint unsigned mag;
      logic [127:0] q;
      logic [127:0] res;
      logic [127:0] lim;
      neg = num < 0;
      mag = neg ? longint'(-num) : longint'(num);
      if (k >= 0) q = (128'(mag) << k) / 128'(len);
      else q = 128'(mag / len) >> (-k);
      lim = neg ? 128'(1) << 31 : (128'(1) << 31) - 1;
      if (q >= (128'(1) << 32)) res = lim + 1;
      else res = (q + 1) >> 1;
      if (res > lim) begin
        res = lim;
        sat = 1'b1;
      end
      if (neg) res = -res;
      return res[31:0];
    endfunction

    function void note_item(longint f[3], longint s[3]);
      deriv_t r;
      longint a[3];
      longint unsigned am[3];
      longint unsigned n[3];
      longint unsigned m, sum, len, dm;
      longint d[3];
      int p, sh, k;
      m = 0;
      r.zl = 0;
      r.sat = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = offset[i] + s[i] - f[i];
        am[i] = a[i] < 0 ? longint'(-a[i]) : longint'(a[i]);
        if (am[i] > m) m = am[i];
        r.dir[i] = 0;
      end
      for (int i = 0; i < 6; i++) r.hess[i] = 0;
      if (m == 0) begin
        r.zl = 1;
      end else begin
        p = 0;
        while (p < 63 && (m >> (p + 1)) != 0) p++;
        sh = p - 30;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          n[i] = (sh > 0) ? (am[i] >> sh) : (am[i] << (-sh));
          sum += n[i] * n[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          dm = ((n[i] << 31) + len) / (len << 1);
          d[i] = a[i] < 0 ? -longint'(dm) : longint'(dm);
          r.dir[i] = d[i][31:0];
        end
        k = 2 * FRAC - 60 - sh + 1;
        for (int i = 0; i < 3; i++)
          r.hess[i] = scale_entry((longint'(1) << 60) - d[i] * d[i], k, len, r.sat);
        r.hess[3] = scale_entry(-(d[0] * d[1]), k, len, r.sat);
        r.hess[4] = scale_entry(-(d[0] * d[2]), k, len, r.sat);
        r.hess[5] = scale_entry(-(d[1] * d[2]), k, len, r.sat);
      end
      pending.push_back(r);
    endfunction

    function void check_result(deriv_t got);
      deriv_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 3; i++)
        if (got.dir[i] !== e.dir[i]) begin
          $display("%0t: dir[%0d] expected %0d actual %0d", $time, i, e.dir[i], got.dir[i]);
          errors++;
        end
      for (int i = 0; i < 6; i++)
        if (got.hess[i] !== e.hess[i]) begin
          $display("%0t: hess[%0d] expected %0d actual %0d", $time, i, e.hess[i],
                   got.hess[i]);
          errors++;
        end
      if (got.zl !== e.zl) begin
        $display("%0t: zero_length expected %0b actual %0b", $time, e.zl, got.zl);
        errors++;
      end
      if (got.sat !== e.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = dcd_pkg::CFG_OFFSET_X;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] first_x = 0, first_y = 0, first_z = 0;
  logic signed [31:0] second_x = 0, second_y = 0, second_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] dir_x, dir_y, dir_z;
  logic signed [31:0] hess_xx, hess_yy, hess_zz, hess_xy, hess_xz, hess_yz;
  logic zero_length, saturated;

  distance_constraint_derivatives u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .hess_xx(hess_xx), .hess_yy(hess_yy), .hess_zz(hess_zz),
    .hess_xy(hess_xy), .hess_xz(hess_xz), .hess_yz(hess_yz),
    .zero_length(zero_length), .saturated(saturated)
  );

  deriv_scoreboard sb = new();
  int tx_idle_pct = 9;
  int rx_idle_pct = 52;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  // Clock generation.
  initial begin
    forever #4 clk = ~clk;
  end

  // Record every accepted input item with the predictor.
  always @(posedge clk) begin
    longint f[3];
    longint s[3];
    if (!rst && in_valid && !in_stall) begin
      f = '{longint'(first_x), longint'(first_y), longint'(first_z)};
      s = '{longint'(second_x), longint'(second_y), longint'(second_z)};
      sb.note_item(f, s);
    end
  end

  // Check every accepted result item.
  always @(posedge clk) begin
    deriv_t r;
    if (!rst && out_valid && !out_stall) begin
      r.dir = '{dir_x, dir_y, dir_z};
      r.hess = '{hess_xx, hess_yy, hess_zz, hess_xy, hess_xz, hess_yz};
      r.zl = zero_length;
      r.sat = saturated;
      sb.check_result(r);
    end
  end

  // Result side stall, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted item or register write.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      dcd_pkg::CFG_OFFSET_X: sb.offset[0] = longint'($signed(val));
      dcd_pkg::CFG_OFFSET_Y: sb.offset[1] = longint'($signed(val));
      dcd_pkg::CFG_OFFSET_Z: sb.offset[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic send_item(logic [31:0] f[3], logic [31:0] s[3]);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_x <= f[0]; first_y <= f[1]; first_z <= f[2];
    second_x <= s[0]; second_y <= s[1]; second_z <= s[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random point pair; the category picks the shape of the difference vector.
  task automatic random_item();
    logic [31:0] f[3];
    logic [31:0] s[3];
    longint lo, hi, v, delta;
    int kind;
    int sc;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      f[i] = $urandom;
      s[i] = $urandom;
      if (kind >= 5 && kind <= 8) begin
        // Place the second point close to first - offset.
        if (kind == 8 || (kind == 7 && i != 0)) begin
          delta = 0;
        end else begin
          sc = $urandom_range(16);
          delta = longint'($signed(17'($urandom))) >>> sc;
        end
        lo = -(longint'(1) << 31);
        hi = (longint'(1) << 31) - 1;
        if (-(longint'(1) << 31) - sb.offset[i] - delta > lo)
          lo = -(longint'(1) << 31) - sb.offset[i] - delta;
        if ((longint'(1) << 31) - 1 - sb.offset[i] - delta < hi)
          hi = (longint'(1) << 31) - 1 - sb.offset[i] - delta;
        v = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
        s[i] = v[31:0];
        f[i] = 32'(v + sb.offset[i] + delta);
      end else if (kind == 9) begin
        f[i] = $urandom_range(1) ? 32'h8000_0000 | $urandom_range(255) : 32'h7fff_ff00;
        s[i] = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(255) : 32'h8000_0000;
      end
    end
    send_item(f, s);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) random_item();
  endtask

  // Main sequence.
  initial begin
    logic [31:0] f[3];
    logic [31:0] s[3];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at reset offsets.
    f = '{0, 0, 0}; s = '{0, 0, 0}; send_item(f, s);
    f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    s = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}; send_item(f, s);
    send_item(s, f);
    f = '{0, 0, 0};
    s = '{1, 0, 0}; send_item(f, s);
    s = '{0, 32'hffff_ffff, 0}; send_item(f, s);
    s = '{0, 0, 1}; send_item(f, s);
    s = '{1, 1, 1}; send_item(f, s);
    s = '{32'h0001_0000, 0, 0}; send_item(f, s);
    s = '{32'h7fff_ffff, 0, 0}; send_item(f, s);
    s = '{0, 32'h8000_0000, 0}; send_item(f, s);
    s = '{32'h0003_0000, 32'h0004_0000, 0}; send_item(f, s);
    s = '{32'hfffd_0000, 32'h0004_0000, 32'h000c_0000}; send_item(f, s);
    s = '{32'h0000_8000, 32'hffff_8000, 32'h0000_8000}; send_item(f, s);
    f = '{32'h1234_5678, 32'h1234_5678, 32'h1234_5678}; send_item(f, f);
    for (int i = 0; i < 6; i++) random_item();
    drain();

    // Extreme offsets.
    write_reg(dcd_pkg::CFG_OFFSET_X, 32'h7fff_ffff);
    write_reg(dcd_pkg::CFG_OFFSET_Y, 32'h8000_0000);
    write_reg(dcd_pkg::CFG_OFFSET_Z, 32'h7fff_ffff);
    f = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    s = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}; send_item(f, s);
    random_phase(360);
    drain();

    // Sender mostly idle now, receiver mostly ready.
    tx_idle_pct = 52;
    rx_idle_pct = 9;
    write_reg(dcd_pkg::CFG_OFFSET_X, $urandom);
    write_reg(dcd_pkg::CFG_OFFSET_Y, 32'($signed($urandom_range(65535)) - 32768));
    write_reg(dcd_pkg::CFG_OFFSET_Z, 32'h8000_0000);
    write_reg(CFG_NONE, $urandom);
    random_phase(360);
    drain();

    // No idling; one long receiver hold-off fills the pipeline.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(dcd_pkg::CFG_OFFSET_X, 0);
    write_reg(dcd_pkg::CFG_OFFSET_Y, $urandom);
    write_reg(dcd_pkg::CFG_OFFSET_Z, 0);
    hold_req = 1;
    random_phase(370);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
